// ----- rtl/wgbd_pkg.sv -----
// Package with shared types, codes and gesture template tables.
package wgbd_pkg;

    localparam int AxW = 13;
    localparam int StandRows = 22;
    localparam int SitRows = 23;
    localparam int WristRows = 21;

    typedef logic signed [AxW-1:0] axis_t;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_ON      = 2'd1,
        REQ_OFF     = 2'd2,
        REQ_AMBIENT = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_USE_AMBIENT  = 3'd0,
        CFG_POWER_EN     = 3'd1,
        CFG_VIEW_X_LOW   = 3'd2,
        CFG_VIEW_X_HIGH  = 3'd3,
        CFG_VIEW_Y_LOW   = 3'd4,
        CFG_VIEW_Y_HIGH  = 3'd5,
        CFG_ON_TIMEOUT   = 3'd6
    } cfg_idx_t;

    // Configuration register set.
    typedef struct packed {
        logic        use_ambient;
        logic        power_events_enabled;
        axis_t       view_x_low;
        axis_t       view_x_high;
        axis_t       view_y_low;
        axis_t       view_y_high;
        logic [9:0]  on_timeout_samples;
    } cfg_t;

    // Per-sample template match flags, one per track.
    typedef struct packed {
        logic stand;
        logic sit;
        logic wrist;
    } match_t;

    // Standing template value; rows past the end read as zero and are masked by the caller.
    function automatic logic signed [12:0] stand_val(input logic [4:0] r, input logic [1:0] ax);
        logic signed [12:0] t [0:2];
        t[0] = '0; t[1] = '0; t[2] = '0;
        case (r)
            5'd0:  begin t[0]=1024; t[1]=536;  t[2]=-168; end
            5'd1:  begin t[0]=1096; t[1]=816;  t[2]=-224; end
            5'd2:  begin t[0]=1128; t[1]=976;  t[2]=-192; end
            5'd3:  begin t[0]=1160; t[1]=1096; t[2]=-200; end
            5'd4:  begin t[0]=1232; t[1]=1288; t[2]=-48;  end
            5'd5:  begin t[0]=1288; t[1]=1312; t[2]=-264; end
            5'd6:  begin t[0]=1280; t[1]=1208; t[2]=-216; end
            5'd7:  begin t[0]=1224; t[1]=1120; t[2]=-336; end
            5'd8:  begin t[0]=1048; t[1]=936;  t[2]=-344; end
            5'd9:  begin t[0]=888;  t[1]=816;  t[2]=-344; end
            5'd10: begin t[0]=688;  t[1]=608;  t[2]=-424; end
            5'd11: begin t[0]=536;  t[1]=432;  t[2]=-408; end
            5'd12: begin t[0]=392;  t[1]=216;  t[2]=-288; end
            5'd13: begin t[0]=264;  t[1]=-8;   t[2]=-376; end
            5'd14: begin t[0]=192;  t[1]=-184; t[2]=-240; end
            5'd15: begin t[0]=120;  t[1]=-408; t[2]=-312; end
            5'd16: begin t[0]=96;   t[1]=-512; t[2]=-344; end
            5'd17: begin t[0]=80;   t[1]=-672; t[2]=-360; end
            5'd18: begin t[0]=72;   t[1]=-824; t[2]=-504; end
            5'd19: begin t[0]=80;   t[1]=-864; t[2]=-448; end
            5'd20: begin t[0]=64;   t[1]=-896; t[2]=-488; end
            5'd21: begin t[0]=64;   t[1]=-888; t[2]=-496; end
            default: begin t[0]='0; t[1]='0; t[2]='0; end
        endcase
        return (ax == 2'd0) ? t[0] : (ax == 2'd1) ? t[1] : t[2];
    endfunction

    function automatic logic signed [12:0] wrist_val(input logic [4:0] r, input logic [1:0] ax);
        logic signed [12:0] t [0:2];
        t[0] = '0; t[1] = '0; t[2] = '0;
        case (r)
            5'd0:  begin t[0]=16;  t[1]=-648; t[2]=-752; end
            5'd1:  begin t[0]=16;  t[1]=-600; t[2]=-800; end
            5'd2:  begin t[0]=24;  t[1]=-520; t[2]=-840; end
            5'd3:  begin t[0]=-8;  t[1]=-320; t[2]=-288; end
            5'd4:  begin t[0]=24;  t[1]=216;  t[2]=-176; end
            5'd5:  begin t[0]=120; t[1]=952;  t[2]=-104; end
            5'd6:  begin t[0]=88;  t[1]=1152; t[2]=-224; end
            5'd7:  begin t[0]=48;  t[1]=1048; t[2]=-352; end
            5'd8:  begin t[0]=24;  t[1]=1040; t[2]=-176; end
            5'd9:  begin t[0]=24;  t[1]=1048; t[2]=-240; end
            5'd10: begin t[0]=24;  t[1]=1056; t[2]=-168; end
            5'd11: begin t[0]=24;  t[1]=1152; t[2]=-184; end
            5'd12: begin t[0]=8;   t[1]=1152; t[2]=-320; end
            5'd13: begin t[0]=8;   t[1]=1072; t[2]=-544; end
            5'd14: begin t[0]=-8;  t[1]=864;  t[2]=-656; end
            5'd15: begin t[0]=-48; t[1]=448;  t[2]=-464; end
            5'd16: begin t[0]=-56; t[1]=-272; t[2]=-544; end
            5'd17: begin t[0]=-64; t[1]=-496; t[2]=-496; end
            5'd18: begin t[0]=40;  t[1]=-456; t[2]=-872; end
            5'd19: begin t[0]=16;  t[1]=-592; t[2]=-800; end
            5'd20: begin t[0]=8;   t[1]=-672; t[2]=-656; end
            default: begin t[0]='0; t[1]='0; t[2]='0; end
        endcase
        return (ax == 2'd0) ? t[0] : (ax == 2'd1) ? t[1] : t[2];
    endfunction

    function automatic logic signed [12:0] sit_val(input logic [4:0] r, input logic [1:0] ax);
        logic signed [12:0] t [0:2];
        t[0] = '0; t[1] = '0; t[2] = '0;
        case (r)
            5'd0:  begin t[0]=-208; t[1]=664;  t[2]=-840;  end
            5'd1:  begin t[0]=-208; t[1]=664;  t[2]=-720;  end
            5'd2:  begin t[0]=-416; t[1]=568;  t[2]=-912;  end
            5'd3:  begin t[0]=-424; t[1]=656;  t[2]=-1000; end
            5'd4:  begin t[0]=-504; t[1]=648;  t[2]=-904;  end
            5'd5:  begin t[0]=-472; t[1]=704;  t[2]=-864;  end
            5'd6:  begin t[0]=-408; t[1]=632;  t[2]=-896;  end
            5'd7:  begin t[0]=-360; t[1]=512;  t[2]=-856;  end
            5'd8:  begin t[0]=-296; t[1]=424;  t[2]=-856;  end
            5'd9:  begin t[0]=-232; t[1]=224;  t[2]=-768;  end
            5'd10: begin t[0]=-200; t[1]=-16;  t[2]=-728;  end
            5'd11: begin t[0]=-160; t[1]=-72;  t[2]=-704;  end
            5'd12: begin t[0]=-136; t[1]=-224; t[2]=-680;  end
            5'd13: begin t[0]=-112; t[1]=-344; t[2]=-632;  end
            5'd14: begin t[0]=-88;  t[1]=-448; t[2]=-600;  end
            5'd15: begin t[0]=-72;  t[1]=-544; t[2]=-600;  end
            5'd16: begin t[0]=-64;  t[1]=-592; t[2]=-560;  end
            5'd17: begin t[0]=-72;  t[1]=-664; t[2]=-520;  end
            5'd18: begin t[0]=-48;  t[1]=-728; t[2]=-520;  end
            5'd19: begin t[0]=-8;   t[1]=-744; t[2]=-584;  end
            5'd20: begin t[0]=16;   t[1]=-776; t[2]=-544;  end
            5'd21: begin t[0]=40;   t[1]=-808; t[2]=-568;  end
            5'd22: begin t[0]=56;   t[1]=-816; t[2]=-608;  end
            default: begin t[0]='0; t[1]='0; t[2]='0; end
        endcase
        return (ax == 2'd0) ? t[0] : (ax == 2'd1) ? t[1] : t[2];
    endfunction

    // True when |v - t| <= tol.
    function automatic logic near_tol(input axis_t v, input logic signed [12:0] t,
                                      input logic [9:0] tol);
        logic signed [14:0] d;
        d = 15'(v) - 15'(t);
        return (d <= $signed({5'd0, tol})) && (d >= -$signed({5'd0, tol}));
    endfunction

endpackage

// ----- rtl/wgbd_if.sv -----
// Valid/ready channel interfaces for samples and results.
interface wgbd_in_if;
    logic          valid;
    logic          ready;
    logic          op;
    logic [12:0]   accel_x;
    logic [12:0]   accel_y;
    logic [12:0]   accel_z;
    logic          last_in_batch;
    logic [31:0]   now_seconds;
    logic          charging;
    logic          plugged;
    modport source (output valid, op, accel_x, accel_y, accel_z, last_in_batch,
                    now_seconds, charging, plugged, input ready);
    modport sink (input valid, op, accel_x, accel_y, accel_z, last_in_batch,
                  now_seconds, charging, plugged, output ready);
endinterface

interface wgbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  light_request;
    logic        lit;
    modport source (output valid, light_request, lit, input ready);
    modport sink (input valid, light_request, lit, output ready);
endinterface

// ----- rtl/wgbd_match.sv -----
// Template match logic: checks a sample against six rows from each step index.
module wgbd_match (
    input  wgbd_pkg::axis_t  x,
    input  wgbd_pkg::axis_t  y,
    input  wgbd_pkg::axis_t  z,
    input  logic [4:0]       stand_step,
    input  logic [4:0]       sit_step,
    input  logic [4:0]       wrist_step,
    output wgbd_pkg::match_t hit
);
    logic [5:0] sx, sz, tx, ty, tz, wx, wy;

    // Each axis is tested across the six rows on its own.
    always_comb
    begin
        logic [5:0] rs, rt, rw;
        for (int k = 0; k < 6; k++)
        begin
            rs = 6'(stand_step) + 6'(k);
            rt = 6'(sit_step) + 6'(k);
            rw = 6'(wrist_step) + 6'(k);
            sx[k] = (rs < 6'(wgbd_pkg::StandRows)) &&
                    wgbd_pkg::near_tol(x, wgbd_pkg::stand_val(rs[4:0], 2'd0), 10'd150);
            sz[k] = (rs < 6'(wgbd_pkg::StandRows)) &&
                    wgbd_pkg::near_tol(z, wgbd_pkg::stand_val(rs[4:0], 2'd2), 10'd200);
            tx[k] = (rt < 6'(wgbd_pkg::SitRows)) &&
                    wgbd_pkg::near_tol(x, wgbd_pkg::sit_val(rt[4:0], 2'd0), 10'd100);
            ty[k] = (rt < 6'(wgbd_pkg::SitRows)) &&
                    wgbd_pkg::near_tol(y, wgbd_pkg::sit_val(rt[4:0], 2'd1), 10'd300);
            tz[k] = (rt < 6'(wgbd_pkg::SitRows)) &&
                    wgbd_pkg::near_tol(z, wgbd_pkg::sit_val(rt[4:0], 2'd2), 10'd250);
            wx[k] = (rw < 6'(wgbd_pkg::WristRows)) &&
                    wgbd_pkg::near_tol(x, wgbd_pkg::wrist_val(rw[4:0], 2'd0), 10'd100);
            wy[k] = (rw < 6'(wgbd_pkg::WristRows)) &&
                    wgbd_pkg::near_tol(y, wgbd_pkg::wrist_val(rw[4:0], 2'd1), 10'd150);
        end
    end

    assign hit.stand = (|sx) && (|sz);
    assign hit.sit   = (|tx) && (|ty) && (|tz);
    assign hit.wrist = (|wx) && (|wy);
endmodule

// ----- rtl/wgbd_cfg.sv -----
// Configuration register file.
module wgbd_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [12:0]     cfg_data,
    output wgbd_pkg::cfg_t  cfg
);
    wgbd_pkg::cfg_t cfg_reg;

    // Register writes by index; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_ambient          <= 1'b0;
            cfg_reg.power_events_enabled <= 1'b0;
            cfg_reg.view_x_low           <= -13'sd200;
            cfg_reg.view_x_high          <= 13'sd200;
            cfg_reg.view_y_low           <= -13'sd1200;
            cfg_reg.view_y_high          <= -13'sd200;
            cfg_reg.on_timeout_samples   <= 10'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wgbd_pkg::CFG_USE_AMBIENT: cfg_reg.use_ambient <= cfg_data[0];
                wgbd_pkg::CFG_POWER_EN:    cfg_reg.power_events_enabled <= cfg_data[0];
                wgbd_pkg::CFG_VIEW_X_LOW:  cfg_reg.view_x_low <= cfg_data;
                wgbd_pkg::CFG_VIEW_X_HIGH: cfg_reg.view_x_high <= cfg_data;
                wgbd_pkg::CFG_VIEW_Y_LOW:  cfg_reg.view_y_low <= cfg_data;
                wgbd_pkg::CFG_VIEW_Y_HIGH: cfg_reg.view_y_high <= cfg_data;
                wgbd_pkg::CFG_ON_TIMEOUT:  cfg_reg.on_timeout_samples <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ----- rtl/wrist_gesture_backlight_detector.sv -----
// Top level of the wrist gesture backlight detector.
// The block takes one request per cycle: samples and power events are registered on
// entry, decided by one pass of template compares and pose checks, and the result
// lands in an output register; a new request is taken every cycle while the output
// register is free or being emptied. Configuration must be written only while idle.
module wrist_gesture_backlight_detector (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [12:0]  cfg_data,
    wgbd_in_if.sink      in_ch,
    wgbd_out_if.source   out_ch
);
    wgbd_pkg::cfg_t   cfg;
    wgbd_pkg::match_t hit;

    // Input stage.
    logic            s_valid_reg;
    logic            s_op_reg, s_last_reg, s_chg_reg, s_plg_reg;
    wgbd_pkg::axis_t s_x_reg, s_y_reg, s_z_reg;
    logic [31:0]     s_now_reg;

    // Detector state.
    logic [4:0]  stand_reg, sit_reg, wrist_reg, look_reg;
    logic [4:0]  stand_next, sit_next, wrist_next, look_next;
    logic [2:0]  settle_reg, settle_next;
    wgbd_pkg::axis_t prev_x_reg, prev_x_next;
    logic        lit_reg, lit_next;
    logic [9:0]  on_count_reg, on_count_next;
    logic [31:0] pending_reg, pending_next;
    logic        charger_reg, charger_next, power_reg, power_next;
    logic        skip_reg, skip_next;
    wgbd_pkg::req_t req_next;

    // Output stage.
    logic        o_valid_reg;
    logic [1:0]  o_req_reg;
    logic        o_lit_reg;

    logic adv;
    logic take;

    assign adv  = s_valid_reg && (!o_valid_reg || out_ch.ready);
    assign take = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s_valid_reg || adv;

    wgbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wgbd_match u_match (
        .x          (s_x_reg),
        .y          (s_y_reg),
        .z          (s_z_reg),
        .stand_step (stand_reg),
        .sit_step   (sit_reg),
        .wrist_step (wrist_reg),
        .hit        (hit)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_op_reg   <= in_ch.op;
            s_x_reg    <= in_ch.accel_x;
            s_y_reg    <= in_ch.accel_y;
            s_z_reg    <= in_ch.accel_z;
            s_last_reg <= in_ch.last_in_batch;
            s_now_reg  <= in_ch.now_seconds;
            s_chg_reg  <= in_ch.charging;
            s_plg_reg  <= in_ch.plugged;
        end
    end

    // Decision logic for one request.
    always_comb
    begin
        logic signed [14:0] dx;
        logic steady, in_x, in_y, fired, off;
        logic [4:0] st_i, si_i, wr_i, lk_i;
        logic [2:0] se_i;

        stand_next = stand_reg; sit_next = sit_reg; wrist_next = wrist_reg;
        look_next = look_reg; settle_next = settle_reg; prev_x_next = prev_x_reg;
        lit_next = lit_reg; on_count_next = on_count_reg; pending_next = pending_reg;
        charger_next = charger_reg; power_next = power_reg; skip_next = skip_reg;
        req_next = wgbd_pkg::REQ_NONE;
        fired = 1'b0; off = 1'b0;

        dx = 15'(s_x_reg) - 15'(prev_x_reg);
        steady = (dx < 15'sd50) && (dx > -15'sd50);
        in_x = (s_x_reg < cfg.view_x_high) && (s_x_reg > cfg.view_x_low);
        in_y = (s_y_reg > cfg.view_y_low) && (s_y_reg < cfg.view_y_high);

        st_i = stand_reg + 5'(hit.stand);
        if (st_i > 5'd22) st_i = '0;
        si_i = sit_reg + 5'(hit.sit);
        if (si_i > 5'd23) si_i = '0;
        if ((s_x_reg < 13'sd200) && (s_x_reg > -13'sd200) && in_y) lk_i = 5'd20;
        else if (look_reg != '0) lk_i = look_reg - 5'd1;
        else lk_i = '0;
        wr_i = wrist_reg + 5'((lk_i != '0) && hit.wrist);
        if (wr_i > 5'd23 || lk_i == '0) wr_i = '0;
        se_i = settle_reg;

        if (s_op_reg)
        begin
            if (cfg.power_events_enabled)
            begin
                if (s_chg_reg)
                begin
                    charger_next = 1'b1; req_next = wgbd_pkg::REQ_OFF; lit_next = 1'b0;
                end
                else if (s_plg_reg)
                begin
                    power_next = 1'b1; req_next = wgbd_pkg::REQ_ON; lit_next = 1'b1;
                end
                else
                begin
                    charger_next = 1'b0; power_next = 1'b0;
                    if (lit_reg)
                    begin
                        req_next = wgbd_pkg::REQ_OFF; lit_next = 1'b0;
                    end
                end
            end
        end
        else if (charger_reg || power_reg)
        begin
            if (s_last_reg) skip_next = 1'b0;
        end
        else
        begin
            if (!skip_reg)
            begin
                if (!lit_reg)
                begin
                    if (in_x && s_z_reg > 13'sd1000 && (steady || se_i == '0))
                    begin
                        se_i = se_i + 3'd1;
                        if (se_i > 3'd4) fired = 1'b1;
                    end
                    if (!fired && (wr_i > 5'd4 || si_i > 5'd8 || st_i > 5'd5 ||
                                   se_i != '0))
                    begin
                        if (in_x && in_y)
                        begin
                            if (steady || se_i == '0)
                            begin
                                se_i = se_i + 3'd1;
                                if (se_i > 3'd6) fired = 1'b1;
                            end
                        end
                        else
                        begin
                            se_i = '0;
                        end
                    end
                    if (fired)
                    begin
                        req_next = wgbd_pkg::REQ_ON;
                        pending_next = s_now_reg;
                        stand_next = '0; sit_next = '0; wrist_next = '0;
                        look_next = '0; settle_next = '0; skip_next = 1'b1;
                    end
                    else
                    begin
                        stand_next = st_i; sit_next = si_i; wrist_next = wr_i;
                        look_next = lk_i; settle_next = se_i; prev_x_next = s_x_reg;
                    end
                end
                else
                begin
                    if (s_y_reg > 13'sd75 || s_x_reg < -13'sd600) off = 1'b1;
                    else
                    begin
                        req_next = wgbd_pkg::REQ_ON;
                        if (11'(on_count_reg) + 11'd1 >= 11'(cfg.on_timeout_samples))
                            off = 1'b1;
                        else
                            on_count_next = on_count_reg + 10'd1;
                    end
                    if (off)
                    begin
                        pending_next = '0; req_next = wgbd_pkg::REQ_OFF;
                        lit_next = 1'b0; on_count_next = '0; skip_next = 1'b1;
                    end
                end
            end
            if (s_last_reg)
            begin
                if (pending_next != '0 && s_now_reg > pending_next)
                begin
                    req_next = cfg.use_ambient ? wgbd_pkg::REQ_AMBIENT : wgbd_pkg::REQ_ON;
                    lit_next = 1'b1;
                    pending_next = '0;
                end
                skip_next = 1'b0;
            end
        end
    end

    // State and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stand_reg <= '0; sit_reg <= '0; wrist_reg <= '0; look_reg <= '0;
            settle_reg <= '0; prev_x_reg <= '0; lit_reg <= 1'b0; on_count_reg <= '0;
            pending_reg <= '0; charger_reg <= 1'b0; power_reg <= 1'b0; skip_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                stand_reg <= stand_next; sit_reg <= sit_next; wrist_reg <= wrist_next;
                look_reg <= look_next; settle_reg <= settle_next;
                prev_x_reg <= prev_x_next; lit_reg <= lit_next;
                on_count_reg <= on_count_next; pending_reg <= pending_next;
                charger_reg <= charger_next; power_reg <= power_next;
                skip_reg <= skip_next;
            end
            if (adv) o_valid_reg <= 1'b1;
            else if (out_ch.ready) o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_req_reg <= req_next;
            o_lit_reg <= lit_next;
        end
    end

    assign out_ch.valid         = o_valid_reg;
    assign out_ch.light_request = o_req_reg;
    assign out_ch.lit           = o_lit_reg;

    // A stalled result must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !out_ch.ready |=> o_valid_reg && $stable(o_req_reg))
        else $error("result changed while stalled");

    // The light only comes on with an on or ambient request, as a power event or a due pending turn-on gives.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && !lit_reg && lit_next |-> req_next != wgbd_pkg::REQ_NONE)
        else $error("light on without request");

    // The wrist track never runs outside the look window.
    assert property (@(posedge clk) disable iff (!rst_n)
        look_reg == '0 |-> wrist_reg == '0)
        else $error("wrist track outside look window");
endmodule
